// ===== hw/rtl/swm_pkg.sv =====
// Shared types and constants of the sliding-window median filter.
// Used by swm_cell and sliding_window_median_unit; no dependencies.
package swm_pkg;

  localparam int WINDOW_MAX = 16;
  localparam int SAMPLE_W   = 32;
  localparam int MEDIAN_W   = SAMPLE_W + 1;
  localparam int CFG_W      = 5;
  localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
  localparam int AGE_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = CFG_W'(3);

  // What one cell shows its neighbors.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] val;
    logic [AGE_W-1:0]           age;
    logic                       gt;        // empty or holds a value above the new sample
    logic                       del_upto;  // the leaving entry sits here or below
  } swm_link_t;

  // Boundary seen below cell 0: no entry, never above the sample.
  localparam swm_link_t LINK_LOW  = '{val: '0, age: '0, gt: 1'b0, del_upto: 1'b0};
  // Boundary seen above the last cell: empty slot.
  localparam swm_link_t LINK_HIGH = '{val: '0, age: '0, gt: 1'b1, del_upto: 1'b0};

endpackage

// ===== hw/rtl/sliding_window_median_unit.sv =====
// Top level of the sliding-window median filter: a sorted chain of cells
// plus fill tracking and a registered output. Depends on swm_pkg, swm_cell.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries sample_i and restart_i.
//   restart_i empties the window before its sample is taken in.
//   Output channel (out_valid_o/out_ready_i) carries median_x2_o, twice the
//   median of the last window_len samples; a transaction is produced only
//   when the window is full after the sample is taken in.
//   cfg_we_i writes window_len (0 acts as 1, above 16 acts as 16) and
//   empties the window; write only while the block is idle.
//   Throughput: one sample per cycle while in_ready_o is high. Every cell
//   compares against the new sample and moves at most one slot in the same
//   cycle as the accept. The median select and add then load the output
//   register once it is free. When the receiver stalls, one result waits in
//   the output register and one in the cell chain; after that in_ready_o
//   drops until out_ready_i.
//   Reset: window empty, window_len = 3, no transaction pending.
module sliding_window_median_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [swm_pkg::CFG_W-1:0]             cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                                  restart_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [swm_pkg::MEDIAN_W-1:0]   median_x2_o
);
  import swm_pkg::*;

  logic [CFG_W-1:0]           window_len_q;
  logic [LEN_W-1:0]           fill_q, fill_d, fill_eff, len;
  logic [AGE_W-1:0]           len_m1, mid_hi, mid_lo;
  logic                       full, result, accept, load;
  logic                       pend_q, pend_d, out_valid_q, out_valid_d;
  logic signed [MEDIAN_W-1:0] median_q, median_d;
  logic [WINDOW_MAX-1:0]      occ;
  swm_link_t                  link [WINDOW_MAX];

  always_comb begin
    if (window_len_q == '0) begin
      len = LEN_W'(1);
    end else if (32'(window_len_q) > 32'(WINDOW_MAX)) begin
      len = LEN_W'(WINDOW_MAX);
    end else begin
      len = LEN_W'(window_len_q);
    end
  end

  assign len_m1   = AGE_W'(len - 1'b1);
  assign fill_eff = restart_i ? '0 : fill_q;
  assign full     = (fill_eff == len);
  assign result   = full || ((fill_eff + 1'b1) == len);

  assign load       = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_q || !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      occ[i] = (LEN_W'(i) < fill_eff);
    end
  end

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    swm_link_t left_s, right_s;
    if (g == 0) begin : g_lo
      assign left_s = LINK_LOW;
    end else begin : g_lo
      assign left_s = link[g-1];
    end
    if (g == WINDOW_MAX - 1) begin : g_hi
      assign right_s = LINK_HIGH;
    end else begin : g_hi
      assign right_s = link[g+1];
    end
    swm_cell u_cell (
      .clk_i    (clk_i),
      .en_i     (accept),
      .occ_i    (occ[g]),
      .full_i   (full),
      .len_m1_i (len_m1),
      .sample_i (sample_i),
      .left_i   (left_s),
      .right_i  (right_s),
      .link_o   (link[g])
    );
  end

  always_comb begin
    if (cfg_we_i) begin
      fill_d = '0;
    end else if (accept) begin
      fill_d = full ? len : fill_eff + 1'b1;
    end else begin
      fill_d = fill_q;
    end
  end

  // Middle entries; equal for an odd window.
  assign mid_hi   = AGE_W'(len >> 1);
  assign mid_lo   = len[0] ? mid_hi : mid_hi - 1'b1;
  assign median_d = MEDIAN_W'(link[mid_lo].val) + MEDIAN_W'(link[mid_hi].val);

  assign pend_d = (accept && result) || (pend_q && !load);

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= WINDOW_LEN_RESET;
      fill_q       <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_len_q <= cfg_wdata_i;
      end
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      median_q <= median_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_x2_o = median_q;

endmodule

// ===== hw/rtl/swm_cell.sv =====
// One slot of the sorted window: value and age, updated from its two neighbors.
// Depends on swm_pkg.
module swm_cell (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic                                 occ_i,
  input  logic                                 full_i,
  input  logic [swm_pkg::AGE_W-1:0]            len_m1_i,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  sample_i,
  input  swm_pkg::swm_link_t                   left_i,
  input  swm_pkg::swm_link_t                   right_i,
  output swm_pkg::swm_link_t                   link_o
);
  import swm_pkg::*;

  logic signed [SAMPLE_W-1:0] val_q, val_d;
  logic [AGE_W-1:0]           age_q, age_d;
  logic                       gt, del, del_upto;
  logic signed [SAMPLE_W-1:0] k_val, kl_val;
  logic [AGE_W-1:0]           k_age, kl_age;
  logic                       k_gt, kl_gt;

  assign gt       = !occ_i || (val_q > sample_i);
  assign del      = full_i && occ_i && (age_q == len_m1_i);
  assign del_upto = left_i.del_upto || del;

  // Window after removal, at this slot and at the slot below.
  always_comb begin
    if (del_upto) begin
      k_val = right_i.val;
      k_age = right_i.age;
      k_gt  = right_i.gt;
    end else begin
      k_val = val_q;
      k_age = age_q;
      k_gt  = gt;
    end
    if (left_i.del_upto) begin
      kl_val = val_q;
      kl_age = age_q;
      kl_gt  = gt;
    end else begin
      kl_val = left_i.val;
      kl_age = left_i.age;
      kl_gt  = left_i.gt;
    end
  end

  // Insert: stay, take the new sample, or shift up from below.
  always_comb begin
    priority if (!k_gt) begin
      val_d = k_val;
      age_d = k_age + 1'b1;
    end else if (!kl_gt) begin
      val_d = sample_i;
      age_d = '0;
    end else begin
      val_d = kl_val;
      age_d = kl_age + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign link_o = '{val: val_q, age: age_q, gt: gt, del_upto: del_upto};

endmodule

// ===== tb/tb.sv =====
// Testbench for sliding_window_median_unit: directed and random sample streams.
// A sorted-window tracker predicts each median and a scoreboard checks it.
// Depends on swm_pkg and the filter RTL.
module tb;
  import swm_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PRINT_MAX    = 20;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh80000000;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CFG_W-1:0]           cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic                       restart_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [MEDIAN_W-1:0] median_x2_o;

  sliding_window_median_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .median_x2_o (median_x2_o)
  );

  // Window tracking on the testbench side
  logic [CFG_W-1:0]           len_setting;
  logic signed [SAMPLE_W-1:0] ring_vals   [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] sorted_vals [WINDOW_MAX];
  int                         held;
  int                         slot;
  logic signed [MEDIAN_W-1:0] medians_due [$];
  logic signed [MEDIAN_W-1:0] want_median;
  logic signed [SAMPLE_W-1:0] last_sample;

  int mismatches;
  int stall_cycles;
  bit idle_on;
  int hold_left;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int active_len();
    if (len_setting == 0) return 1;
    if (len_setting > WINDOW_MAX) return WINDOW_MAX;
    return int'(len_setting);
  endfunction

  // Remove one copy of v from the first count sorted entries.
  function automatic void drop_sorted(input int count, input logic signed [SAMPLE_W-1:0] v);
    int pos;
    pos = count;
    for (int i = 0; i < count; i++) begin
      if (sorted_vals[i] == v) begin
        pos = i;
        break;
      end
    end
    for (int i = pos; i + 1 < count; i++) sorted_vals[i] = sorted_vals[i+1];
  endfunction

  function automatic void add_sorted(input int count, input logic signed [SAMPLE_W-1:0] v);
    int i;
    i = count;
    while (i > 0 && sorted_vals[i-1] > v) begin
      sorted_vals[i] = sorted_vals[i-1];
      i--;
    end
    sorted_vals[i] = v;
  endfunction

  // Take one sample into the window; queue twice the median once it is full.
  function automatic void advance_window(input logic signed [SAMPLE_W-1:0] s,
                                         input logic restart);
    int len;
    logic signed [MEDIAN_W-1:0] lo, hi;
    len = active_len();
    if (restart) begin
      held = 0;
      slot = 0;
    end
    if (held > len) held = len;
    if (slot >= len) slot = 0;
    if (held < len) begin
      ring_vals[slot] = s;
      add_sorted(held, s);
      held++;
    end else begin
      drop_sorted(len, ring_vals[slot]);
      add_sorted(len - 1, s);
      ring_vals[slot] = s;
    end
    slot++;
    if (slot >= len) slot = 0;
    if (held == len) begin
      hi = sorted_vals[len/2];
      lo = (len % 2 != 0) ? hi : sorted_vals[len/2 - 1];
      medians_due.push_back(lo + hi);
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] next_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(9))
      0, 1, 2, 3: s = $urandom;
      4, 5, 6:    s = $signed($urandom_range(8)) - 4;  // many equal values
      7:          s = $urandom_range(1) ? S_MAX : S_MIN;
      8:          s = ($urandom_range(1) ? S_MAX : S_MIN) ^ $urandom_range(3);
      default:    s = last_sample;
    endcase
    last_sample = s;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [MEDIAN_W-1:0] got,
                                 input logic signed [MEDIAN_W-1:0] want);
    if (mismatches < PRINT_MAX)
      $display("%0t: %s: got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic restart);
    @(negedge clk_i);
    if (idle_on && $urandom_range(99) < 20) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i   = s;
    restart_i  = restart;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    advance_window(s, restart);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    sample_i   = $urandom;
    restart_i  = $urandom_range(1);
  endtask

  // Only while idle: every median delivered and the pipeline flushed.
  task automatic write_window_len(input logic [CFG_W-1:0] v);
    stop_sending();
    wait (medians_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    len_setting = v;
    held        = 0;
    slot        = 0;
  endtask

  task automatic test_full_scale();
    // window of 3 from reset
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(-32'sd1, 1'b0);
  endtask

  task automatic test_restart();
    send_sample(32'sd10, 1'b1);
    send_sample(32'sd20, 1'b0);
    send_sample(32'sd7, 1'b1);
    send_sample(32'sd8, 1'b0);
    send_sample(32'sd9, 1'b0);
    send_sample(32'sd3, 1'b1);
  endtask

  task automatic test_even_window();
    write_window_len(CFG_W'(2));
    send_sample(S_MAX, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MIN, 1'b0);
  endtask

  task automatic test_length_codes();
    write_window_len(CFG_W'(0));  // acts as 1
    send_sample(32'sd5, 1'b0);
    send_sample(-32'sd5, 1'b0);
    write_window_len(CFG_W'(2));
    send_sample(32'sd1, 1'b0);
    // same value again still empties the window
    write_window_len(CFG_W'(2));
    send_sample(32'sd4, 1'b0);
    send_sample(32'sd4, 1'b0);
    write_window_len(CFG_W'(31));  // acts as 16
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
  endtask

  task automatic test_backpressure();
    write_window_len(CFG_W'(4));
    idle_on   = 1'b0;
    hold_left = 60;
    repeat (30) send_sample(next_sample(), 1'b0);
    idle_on   = 1'b1;
  endtask

  task automatic test_random();
    int lens [15] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 12, 15, 16, 17, 31, 0};
    foreach (lens[k]) begin
      write_window_len(CFG_W'(lens[k]));
      repeat (33) send_sample(next_sample(), $urandom_range(99) < 3);
    end
    // long stretch without idling on either side
    write_window_len(CFG_W'($urandom_range(31)));
    idle_on = 1'b0;
    repeat (60) send_sample(next_sample(), $urandom_range(99) < 3);
    idle_on = 1'b1;
  endtask

  // Receiver: random stalls, plus a counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else if (idle_on && $urandom_range(99) < 30) begin
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // Scoreboard: each median transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (medians_due.size() == 0) begin
        report_mismatch("median with none due", median_x2_o, '0);
      end else begin
        want_median = medians_due.pop_front();
        if (median_x2_o !== want_median)
          report_mismatch("median_x2 mismatch", median_x2_o, want_median);
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("%0t: timeout, no transaction for %0d cycles, %0d medians due",
             $time, STALL_LIMIT, medians_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    restart_i   = 1'b0;
    out_ready_i = 1'b0;
    len_setting = WINDOW_LEN_RESET;
    held        = 0;
    slot        = 0;
    last_sample = '0;
    mismatches  = 0;
    idle_on     = 1'b1;
    hold_left   = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_full_scale();
    test_restart();
    test_even_window();
    test_length_codes();
    test_backpressure();
    test_random();

    stop_sending();
    wait (medians_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/swm_pkg.sv
hw/rtl/swm_cell.sv
hw/rtl/sliding_window_median_unit.sv
tb/tb.sv
